// File: sv/decimal_digit_reverser_defines.svh
// assertion macros for the decimal digit reverser
// no dependencies; included by files that carry concurrent assertions
`ifndef DECIMAL_DIGIT_REVERSER_DEFINES_SVH
`define DECIMAL_DIGIT_REVERSER_DEFINES_SVH
`ifndef ASSERT_OFF
`define DDR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DDR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define DDR_ASSERT(lbl, clk, rst_n, prop, msg)
`define DDR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: sv/ddr_pkg.sv
// package for the decimal digit reverser: constants and pipeline stage type
// no dependencies
package ddr_pkg;

	localparam int NUM_DIGITS = 10;
	localparam int QUO_W = 28;
	localparam int RECIP_SHIFT = 35;
	localparam logic [31:0] RECIP = 32'hCCCC_CCCD;
	localparam logic [31:0] LIMIT_DIV = 32'd214748364;
	localparam logic [3:0] POS_LAST_DIGIT = 4'd7;
	localparam logic [3:0] NEG_LAST_DIGIT = 4'd8;

	typedef struct packed {
		logic              neg;
		logic              ovf;
		logic [31:0]       mag;
		logic [QUO_W-1:0]  quo;
		logic [31:0]       acc;
	} stage_t;

endpackage

// File: sv/decimal_digit_reverser.sv
// decimal digit reverser: an accepted start passes the input register, the digit steps and the output register to done
// throughput one item per cycle; busy is always low
// ten digit steps of two stages each (reciprocal multiply, then digit extract and accumulate)
// asynchronous active-low reset clears all valid bits and done
// depends on ddr_pkg and decimal_digit_reverser_defines.svh
`include "decimal_digit_reverser_defines.svh"

module decimal_digit_reverser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] value,
	output logic               done,
	output logic signed [31:0] reversed,
	output logic               overflow
);

	logic                      v_s1;
	ddr_pkg::stage_t           in_d;
	ddr_pkg::stage_t           in_s1;
	logic                      va_s [ddr_pkg::NUM_DIGITS];
	logic                      vb_s [ddr_pkg::NUM_DIGITS];
	ddr_pkg::stage_t           a_s  [ddr_pkg::NUM_DIGITS];
	ddr_pkg::stage_t           b_s  [ddr_pkg::NUM_DIGITS];
	logic               [31:0] res_d;

	assign busy = 1'b0;

	always_comb begin
		in_d.neg = value[31];
		in_d.ovf = 1'b0;
		in_d.mag = value[31] ? (32'd0 - value) : value;
		in_d.quo = '0;
		in_d.acc = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		in_s1 <= in_d;
	end

	for (genvar i = 0; i < ddr_pkg::NUM_DIGITS; i++) begin : g_digit
		logic            v_in;
		ddr_pkg::stage_t st_in;
		logic     [63:0] prod;
		ddr_pkg::stage_t a_d;
		logic     [31:0] ten_q;
		logic     [31:0] diff;
		logic      [3:0] dig;
		logic      [3:0] last;
		logic            lim;
		ddr_pkg::stage_t b_d;

		if (i == 0) begin : g_first
			assign v_in  = v_s1;
			assign st_in = in_s1;
		end else begin : g_next
			assign v_in  = vb_s[i-1];
			assign st_in = b_s[i-1];
		end

		always_comb begin
			prod    = {32'd0, st_in.mag} * {32'd0, ddr_pkg::RECIP};
			a_d     = st_in;
			a_d.quo = prod[ddr_pkg::RECIP_SHIFT +: ddr_pkg::QUO_W];
		end

		always_comb begin
			ten_q = {1'b0, a_s[i].quo, 3'b000} + {3'b000, a_s[i].quo, 1'b0};
			diff  = a_s[i].mag - ten_q;
			dig   = diff[3:0];
			last  = a_s[i].neg ? ddr_pkg::NEG_LAST_DIGIT : ddr_pkg::POS_LAST_DIGIT;
			lim   = (a_s[i].acc > ddr_pkg::LIMIT_DIV) ||
			        ((a_s[i].acc == ddr_pkg::LIMIT_DIV) && (dig > last));
			b_d   = a_s[i];
			if ((a_s[i].mag != 32'd0) && !a_s[i].ovf) begin
				b_d.mag = {{(32 - ddr_pkg::QUO_W){1'b0}}, a_s[i].quo};
				if (lim) begin
					b_d.ovf = 1'b1;
				end else begin
					b_d.acc = {a_s[i].acc[28:0], 3'b000} + {a_s[i].acc[30:0], 1'b0}
					        + {28'd0, dig};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				va_s[i] <= 1'b0;
				vb_s[i] <= 1'b0;
			end else begin
				va_s[i] <= v_in;
				vb_s[i] <= va_s[i];
			end
		end

		always_ff @(posedge clk) begin
			a_s[i] <= a_d;
			b_s[i] <= b_d;
		end
	end

	always_comb begin
		if (b_s[ddr_pkg::NUM_DIGITS-1].ovf) begin
			res_d = 32'd0;
		end else if (b_s[ddr_pkg::NUM_DIGITS-1].neg) begin
			res_d = 32'd0 - b_s[ddr_pkg::NUM_DIGITS-1].acc;
		end else begin
			res_d = b_s[ddr_pkg::NUM_DIGITS-1].acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vb_s[ddr_pkg::NUM_DIGITS-1];
		end
	end

	always_ff @(posedge clk) begin
		reversed <= signed'(res_d);
		overflow <= b_s[ddr_pkg::NUM_DIGITS-1].ovf;
	end

	// overflowed items come out as zero
	`DDR_ASSERT_IMP(a_ovf_zero, clk, arst_n, done && overflow, reversed == 32'sd0, "overflow with nonzero result")
	// every accepted item comes out at done
	`DDR_ASSERT_IMP(a_latency, clk, arst_n, start && !busy, ##22 done, "item lost in pipeline")
	// no result without an item accepted at the matching cycle
	`DDR_ASSERT_IMP(a_no_extra, clk, arst_n, done, $past(start && !busy, 22), "result without item")
	// a nonzero in-range result keeps the sign of its input
	`DDR_ASSERT_IMP(a_sign, clk, arst_n, done && !overflow && (reversed != 32'sd0), reversed[31] == $past(value[31], 22), "sign mismatch")

endmodule

// File: bench/decimal_digit_reverser_tb.sv
`timescale 1ns / 1ps
// testbench for decimal_digit_reverser: directed table, then weighted random items
// typed rows check the table, others an in-bench digit reversal predictor
// depends on the decimal_digit_reverser rtl only
module decimal_digit_reverser_tb;

	localparam int NUM_DIRECTED = 21;
	localparam int NUM_RANDOM = 1530;
	localparam int CALM_TAIL = 200;
	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT = 3000;
	localparam int MAX_REPORTS = 10;
	localparam longint RADIX = 10;
	localparam longint STEP_LIMIT = 214748364;
	localparam longint POS_LAST_DIGIT = 7;
	localparam longint NEG_LAST_DIGIT = -8;

	typedef struct packed {
		logic signed [31:0] reversed;
		logic               overflow;
	} reversal_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               typed;
		logic signed [31:0] reversed;
		logic               overflow;
	} vector_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] value;
	logic               done;
	logic signed [31:0] reversed;
	logic               overflow;

	reversal_t pending_reversals [$];
	bit        item_typed;
	reversal_t item_expected;
	int        mismatch_count;
	int        results_checked;
	int        overflows_seen;
	int        negatives_seen;
	int        items_sent;
	int        stall_cycles;

	vector_t directed_vectors [NUM_DIRECTED] = '{
		'{32'sd0,           1'b1, 32'sd0,           1'b0},
		'{32'sd1,           1'b1, 32'sd1,           1'b0},
		'{-32'sd1,          1'b1, -32'sd1,          1'b0},
		'{32'sd120,         1'b1, 32'sd21,          1'b0},
		'{32'sd123,         1'b1, 32'sd321,         1'b0},
		'{-32'sd123,        1'b1, -32'sd321,        1'b0},
		'{32'sh7fffffff,    1'b1, 32'sd0,           1'b1},
		'{32'sh80000000,    1'b1, 32'sd0,           1'b1},
		'{32'sd1000000000,  1'b1, 32'sd1,           1'b0},
		'{-32'sd1000000000, 1'b1, -32'sd1,          1'b0},
		'{32'sd1463847412,  1'b1, 32'sd2147483641,  1'b0},
		'{-32'sd1463847412, 1'b1, -32'sd2147483641, 1'b0},
		'{32'sd1563847412,  1'b1, 32'sd0,           1'b1},
		'{32'sd1000000003,  1'b1, 32'sd0,           1'b1},
		'{-32'sd1000000003, 1'b1, 32'sd0,           1'b1},
		'{32'sd1000000002,  1'b1, 32'sd2000000001,  1'b0},
		'{32'sh55555555,    1'b0, 32'sd0,           1'b0},
		'{32'shaaaaaaaa,    1'b0, 32'sd0,           1'b0},
		'{32'sd1534236469,  1'b0, 32'sd0,           1'b0},
		'{32'sd999999999,   1'b0, 32'sd0,           1'b0},
		'{-32'sd999999999,  1'b0, 32'sd0,           1'b0}
	};

	decimal_digit_reverser u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.value    (value),
		.done     (done),
		.reversed (reversed),
		.overflow (overflow)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic reversal_t reverse_digits(input logic signed [31:0] v);
		longint    rest;
		longint    acc;
		longint    digit;
		reversal_t res;
		rest = v;
		acc = 0;
		res.overflow = 1'b0;
		while (rest != 0 && !res.overflow) begin
			digit = rest % RADIX;
			rest = rest / RADIX;
			if (acc > STEP_LIMIT || (acc == STEP_LIMIT && digit > POS_LAST_DIGIT) ||
					acc < -STEP_LIMIT || (acc == -STEP_LIMIT && digit < NEG_LAST_DIGIT))
				res.overflow = 1'b1;
			else
				acc = acc * RADIX + digit;
		end
		res.reversed = res.overflow ? 32'sd0 : acc[31:0];
		return res;
	endfunction

	function automatic logic signed [31:0] random_value();
		int v;
		int digits;
		int scale;
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: v = $urandom_range(0, 999);
			2: v = $urandom_range(1000000000, 2147483647);
			3: v = $urandom_range(1400000000, 1600000000);
			4: begin
				scale = 10 ** $urandom_range(1, 4);
				v = $urandom_range(1, 99999) * scale;
			end
			default: begin
				digits = $urandom_range(1, 9);
				v = $urandom_range(0, 10 ** digits - 1);
			end
		endcase
		if ($urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	// item acceptance, result checking and stall watchdog
	always @(posedge clk) begin
		reversal_t want;
		if (start && !busy)
			pending_reversals.push_back(item_typed ? item_expected : reverse_digits(value));
		if (done) begin
			results_checked++;
			if (overflow)
				overflows_seen++;
			if (reversed < 0)
				negatives_seen++;
			if (pending_reversals.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result: reversed %0d overflow %0b", reversed, overflow);
			end else begin
				want = pending_reversals.pop_front();
				if (reversed !== want.reversed || overflow !== want.overflow) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("mismatch: expected reversed %0d overflow %0b, got %0d %0b",
							want.reversed, want.overflow, reversed, overflow);
				end
			end
		end
		if ((start && !busy) || done)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no item or result for %0d cycles", STALL_LIMIT);
			$display("decimal_digit_reverser_tb failed");
			$finish;
		end
	end

	task automatic send_item(input logic signed [31:0] v, input bit typed,
			input reversal_t known);
		@(negedge clk);
		start <= 1'b1;
		value <= v;
		item_typed = typed;
		item_expected = known;
		do
			@(posedge clk);
		while (busy);
		items_sent++;
	endtask

	task automatic idle_gap(input int cycles);
		@(negedge clk);
		start <= 1'b0;
		value <= $urandom;
		repeat (cycles - 1)
			@(negedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending_reversals.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		reversal_t known;
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		item_typed = 1'b0;
		item_expected = '0;
		mismatch_count = 0;
		results_checked = 0;
		overflows_seen = 0;
		negatives_seen = 0;
		items_sent = 0;
		stall_cycles = 0;
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			known.reversed = directed_vectors[i].reversed;
			known.overflow = directed_vectors[i].overflow;
			send_item(directed_vectors[i].value, directed_vectors[i].typed, known);
			if (i % 4 == 3)
				idle_gap($urandom_range(1, 12));
		end
		wait_drained();

		for (int i = 0; i < NUM_RANDOM; i++) begin
			if (i < NUM_RANDOM - CALM_TAIL && $urandom_range(0, 3) == 0)
				idle_gap($urandom_range(1, 12));
			if (i == NUM_RANDOM / 2)
				wait_drained();
			send_item(random_value(), 1'b0, '0);
		end
		wait_drained();
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (pending_reversals.size() != 0)
			mismatch_count += pending_reversals.size();
		$display("sent %0d items (%0d from the table), checked %0d results", items_sent,
			NUM_DIRECTED, results_checked);
		$display("results with overflow: %0d, negative results: %0d, mismatches: %0d",
			overflows_seen, negatives_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("decimal_digit_reverser_tb passed");
		else
			$display("decimal_digit_reverser_tb failed");
		$finish;
	end

endmodule

// File: files.f
+incdir+sv
sv/ddr_pkg.sv
sv/decimal_digit_reverser.sv
bench/decimal_digit_reverser_tb.sv
